/* rtl/bfns_pkg.sv */
// ----------------------------------------------------------------------------
// bfns_pkg: shared types and constants for the bitmap find-next-set block
// Request codes, storage word geometry, and the command/status bundles that
// connect the controller to the datapath.
// ----------------------------------------------------------------------------
package bfns_pkg;

	// Payload widths
	localparam int IDX_W  = 11;         // size and found index
	localparam int BIDX_W = 10;         // request bit index
	localparam int LIM_W  = IDX_W + 1;  // bit limits that may reach 2^IDX_W

	// Storage word: 64 bits, bit offset o within a word is bit index base + o
	localparam int WORD_W  = 64;
	localparam int WORD_LG = 6;

	localparam logic [IDX_W-1:0] SIZE_RST = IDX_W'(1024);
	localparam int               IDX_MAX  = (1 << IDX_W) - 1;

	typedef logic [LIM_W-1:0] lim_t;

	typedef enum logic [1:0] {
		REQ_READ  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_FILL  = 2'd2,
		REQ_FIND  = 2'd3
	} req_t;

	// Controller to datapath
	typedef struct packed {
		logic clear;     // write zero word at pointer, advance
		logic accept;    // latch request, load default result, issue first read
		logic rd_res;    // capture read bit
		logic wr_word;   // write back word with one bit changed
		logic fill;      // write merged fill word, advance
		logic search;    // scan one word, advance
		logic load_out;  // move result into output register
	} bfns_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic req_err;    // incoming index out of range (not a fill)
		logic fill_none;  // fill touches no byte
		logic clr_last;   // clearing last word
		logic fill_last;  // fill word is the last one touched
		logic srch_hit;   // set bit found in current word
		logic srch_last;  // current word is the last one in range
	} bfns_stat_t;

endpackage

/* rtl/bfns_ram.sv */
// ----------------------------------------------------------------------------
// bfns_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bfns_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/bfns_dp.sv */
// ----------------------------------------------------------------------------
// bfns_dp: datapath of the bitmap find-next-set block
// Size register, word store, word pointer, bit masks, lowest-set-bit encoder,
// result and output registers.
// ----------------------------------------------------------------------------
module bfns_dp #(
	parameter int MAX_BITS = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [bfns_pkg::IDX_W-1:0] cfg_wdata,
	input  logic [1:0]                 req_type,
	input  logic [bfns_pkg::BIDX_W-1:0] bit_index,
	input  logic                       bit_value,
	input  bfns_pkg::bfns_cmd_t        cmd,
	output bfns_pkg::bfns_stat_t       stat,
	output logic                       read_bit,
	output logic                       found,
	output logic [bfns_pkg::IDX_W-1:0] found_index,
	output logic                       index_error
);
	import bfns_pkg::*;

	localparam int DEPTH = (MAX_BITS + WORD_W - 1) / WORD_W;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CAP   = (MAX_BITS > IDX_MAX) ? IDX_MAX : MAX_BITS;

	// Mask of word bits whose index base + o lies below lim
	function automatic logic [WORD_W-1:0] lim_mask(lim_t base, lim_t lim);
		lim_t              diff;
		logic [WORD_W-1:0] m;
		diff = lim - base;
		if (lim <= base) begin
			m = '0;
		end else if (diff >= lim_t'(WORD_W)) begin
			m = '1;
		end else begin
			m = ~({WORD_W{1'b1}} << diff[WORD_LG-1:0]);
		end
		return m;
	endfunction

	logic [IDX_W-1:0]  size_q;
	logic [IDX_W-1:0]  eff_size;
	logic [BIDX_W-1:0] start_q;
	logic              val_q;
	logic [AW-1:0]     ptr_q;
	logic [AW-1:0]     raddr;
	logic [AW-1:0]     in_word;
	logic [AW-1:0]     start_word;
	logic [WORD_LG-1:0] off;
	logic              we;
	logic [WORD_W-1:0] wdata;
	logic [WORD_W-1:0] rdata;
	logic [WORD_W-1:0] wr_word;
	logic [WORD_W-1:0] fill_mask;
	logic [WORD_W-1:0] lo_mask;
	logic [WORD_W-1:0] hit_vec;
	logic [WORD_W-1:0] hit_one;
	logic [WORD_LG-1:0] enc;
	lim_t              base;
	lim_t              next_base;
	lim_t              size_lim;
	lim_t              fill_lim;
	logic [IDX_W-1:0]  hit_idx;
	logic              in_err;

	logic              res_rd_q;
	logic              res_fnd_q;
	logic [IDX_W-1:0]  res_idx_q;
	logic              res_err_q;
	logic              out_rd_q;
	logic              out_fnd_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic              out_err_q;

	// Size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RST;
		end else if (cfg_we) begin
			size_q <= cfg_wdata;
		end
	end

	assign eff_size = (size_q > IDX_W'(CAP)) ? IDX_W'(CAP) : size_q;
	assign size_lim = {1'b0, eff_size};
	assign fill_lim = (size_lim + lim_t'(7)) & ~lim_t'(7);

	assign in_word    = AW'(bit_index >> WORD_LG);
	assign start_word = AW'(start_q >> WORD_LG);
	assign off        = start_q[WORD_LG-1:0];
	assign base       = {(LIM_W-WORD_LG)'(ptr_q), {WORD_LG{1'b0}}};
	assign next_base  = base + lim_t'(WORD_W);

	assign in_err = (req_type != REQ_FILL) && ({1'b0, bit_index} >= eff_size);

	// Search masks and lowest-set-bit encode
	assign lo_mask = (ptr_q == start_word) ? ({WORD_W{1'b1}} << off) : '1;
	assign hit_vec = rdata & lo_mask & lim_mask(base, size_lim);
	assign hit_one = hit_vec & (~hit_vec + WORD_W'(1));

	always_comb begin
		enc = '0;
		for (int o = 0; o < WORD_W; o++) begin
			if (hit_one[o]) begin
				enc = enc | WORD_LG'(o);
			end
		end
	end

	assign hit_idx = IDX_W'(base | lim_t'(enc));

	assign stat.req_err   = in_err;
	assign stat.fill_none = (eff_size == '0);
	assign stat.clr_last  = (ptr_q == AW'(DEPTH - 1));
	assign stat.fill_last = (next_base >= fill_lim);
	assign stat.srch_hit  = |hit_vec;
	assign stat.srch_last = (next_base >= size_lim);

	// Read address: first word on accept, look-ahead while streaming
	always_comb begin
		if (cmd.accept) begin
			raddr = (req_type == REQ_FILL) ? '0 : in_word;
		end else if (cmd.fill || cmd.search) begin
			raddr = ptr_q + AW'(1);
		end else begin
			raddr = ptr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (cmd.accept) begin
			ptr_q <= raddr;
		end else if (cmd.clear || cmd.fill || cmd.search) begin
			ptr_q <= ptr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			start_q <= bit_index;
			val_q   <= bit_value;
		end
	end

	// Write data
	assign fill_mask = lim_mask(base, fill_lim);

	always_comb begin
		wr_word      = rdata;
		wr_word[off] = val_q;
	end

	assign we = cmd.clear || cmd.wr_word || cmd.fill;

	always_comb begin
		priority if (cmd.clear) begin
			wdata = '0;
		end else if (cmd.wr_word) begin
			wdata = wr_word;
		end else begin
			wdata = (rdata & ~fill_mask) | (val_q ? fill_mask : '0);
		end
	end

	bfns_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(ptr_q),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Result staging
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			res_rd_q  <= 1'b0;
			res_fnd_q <= 1'b0;
			res_err_q <= in_err;
			res_idx_q <= (in_err && req_type == REQ_FIND) ? eff_size : '0;
		end else if (cmd.rd_res) begin
			res_rd_q <= rdata[off];
		end else if (cmd.search && (stat.srch_hit || stat.srch_last)) begin
			res_fnd_q <= stat.srch_hit;
			res_idx_q <= stat.srch_hit ? hit_idx : eff_size;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_rd_q  <= res_rd_q;
			out_fnd_q <= res_fnd_q;
			out_idx_q <= res_idx_q;
			out_err_q <= res_err_q;
		end
	end

	assign read_bit    = out_rd_q;
	assign found       = out_fnd_q;
	assign found_index = out_idx_q;
	assign index_error = out_err_q;

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.search && stat.srch_hit) |-> (hit_idx < eff_size))
		else $error("search hit beyond size");

	a_ptr_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.search || cmd.fill) |-> (ptr_q <= AW'(DEPTH - 1)))
		else $error("word pointer beyond store");

	a_start_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.search || cmd.wr_word || cmd.rd_res) |-> ({1'b0, start_q} < eff_size))
		else $error("store access for an out-of-range index");

endmodule

/* rtl/bfns_ctrl.sv */
// ----------------------------------------------------------------------------
// bfns_ctrl: controller of the bitmap find-next-set block
// Clearing pass, request dispatch, word scan sequencing, output handshake.
// ----------------------------------------------------------------------------
module bfns_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           req_type,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  bfns_pkg::bfns_stat_t stat,
	output bfns_pkg::bfns_cmd_t  cmd
);
	import bfns_pkg::*;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_READ  = 7'b0000100,
		S_WRITE = 7'b0001000,
		S_FILL  = 7'b0010000,
		S_FIND  = 7'b0100000,
		S_RESP  = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					cmd.accept = 1'b1;
					if (req_type == REQ_FILL) begin
						state_d = stat.fill_none ? S_RESP : S_FILL;
					end else if (stat.req_err) begin
						state_d = S_RESP;
					end else if (req_type == REQ_READ) begin
						state_d = S_READ;
					end else if (req_type == REQ_WRITE) begin
						state_d = S_WRITE;
					end else begin
						state_d = S_FIND;
					end
				end
			end
			S_READ: begin
				cmd.rd_res = 1'b1;
				state_d    = S_RESP;
			end
			S_WRITE: begin
				cmd.wr_word = 1'b1;
				state_d     = S_RESP;
			end
			S_FILL: begin
				cmd.fill = 1'b1;
				if (stat.fill_last) begin
					state_d = S_RESP;
				end
			end
			S_FIND: begin
				cmd.search = 1'b1;
				if (stat.srch_hit || stat.srch_last) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("accepted a transaction while busy");

	a_load_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result overwrote a pending output");

	a_valid_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_RESP))
		else $error("output valid raised outside response state");

endmodule

/* rtl/bitmap_find_next_set.sv */
// ----------------------------------------------------------------------------
// bitmap_find_next_set: bit store with read, write, fill and find-next-set
// Bits are kept in 64-bit words; a search or fill scans one word per cycle.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Payload                                   Dir
//  -------  -------------------  ----------------------------------------  ---
//  config   cfg_we               cfg_wdata (size_bits)                     in
//  request  in_valid / in_ready  req_type, bit_index, bit_value            in
//  result   out_valid/out_ready  read_bit, found, found_index, index_error out
//
//  Read and write read the word, use it, then respond.
//  Find scans words from the start word up to the hit or up to the
//    effective size; fill scans the words that ceil8(size) covers.
//    The single word port of the store is why words are scanned one by one.
//  Out-of-range requests, and fills at size zero, skip the store and go to the response step.
//  After reset the store is zeroed by a clearing pass over all
//    ceil(MAX_BITS/64) words (16 by default); in_ready stays low, config writes are taken.
//  A finished result sits in the output register while the next request is
//    accepted; a stalled output only holds the block in its response step.
//
// ----------------------------------------------------------------------------
module bitmap_find_next_set #(
	parameter int MAX_BITS = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bfns_pkg::IDX_W-1:0]  cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  req_type,
	input  logic [bfns_pkg::BIDX_W-1:0] bit_index,
	input  logic                        bit_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        read_bit,
	output logic                        found,
	output logic [bfns_pkg::IDX_W-1:0]  found_index,
	output logic                        index_error
);
	import bfns_pkg::*;

	// Controller and datapath talk only through these bundles
	bfns_cmd_t  cmd;
	bfns_stat_t stat;

	// Sequencer: clearing pass, dispatch per request type, word scan loop,
	// output register handshake.
	bfns_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Storage, size register, masking, bit search and result registers.
	// The effective size saturates at MAX_BITS, capped at 2047; fills cover whole bytes.
	bfns_dp #(
		.MAX_BITS(MAX_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req_type   (req_type),
		.bit_index  (bit_index),
		.bit_value  (bit_value),
		.cmd        (cmd),
		.stat       (stat),
		.read_bit   (read_bit),
		.found      (found),
		.found_index(found_index),
		.index_error(index_error)
	);

endmodule

/* test/bfns_answer_checker.sv */
// ----------------------------------------------------------------------------
// bfns_answer_checker: response predictor and comparator for find-next-set
// Mirrors the bit store and size register from the observed config writes and
// accepted requests, queues the expected answers and checks every response.
// ----------------------------------------------------------------------------
module bfns_answer_checker #(
	parameter int MAX_BITS = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bfns_pkg::IDX_W-1:0]  cfg_wdata,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [1:0]                  req_type,
	input  logic [bfns_pkg::BIDX_W-1:0] bit_index,
	input  logic                        bit_value,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic                        read_bit,
	input  logic                        found,
	input  logic [bfns_pkg::IDX_W-1:0]  found_index,
	input  logic                        index_error,
	output int                          pending,
	output int                          errors,
	output int                          hits,
	output int                          oor
);
	timeunit 1ns;
	timeprecision 1ps;

	import bfns_pkg::*;

	localparam int NBYTES = (MAX_BITS + 7) / 8;

	typedef struct packed {
		logic             read_bit;
		logic             found;
		logic [IDX_W-1:0] found_index;
		logic             index_error;
	} answer_t;

	logic [7:0]       bitmap [NBYTES];
	logic [IDX_W-1:0] size_reg;
	answer_t          answers_due [$];

	function automatic int used_bits();
		return (int'(size_reg) > MAX_BITS) ? MAX_BITS : int'(size_reg);
	endfunction

	// MSB-first within each byte
	function automatic logic bit_at(int i);
		return bitmap[i >> 3][7 - (i & 7)];
	endfunction

	// Applies one request to the mirrored store and returns its answer
	function automatic answer_t apply_request(req_t rq, logic [BIDX_W-1:0] idx, logic val);
		answer_t a;
		int      lim;
		int      pos;
		a   = '0;
		lim = used_bits();
		pos = int'(idx);
		if (rq == REQ_FILL) begin
			// whole bytes, so spare bits of a partial last byte follow the fill
			for (int b = 0; b < (lim + 7) / 8; b++)
				bitmap[b] = val ? 8'hff : 8'h00;
		end else if (pos >= lim) begin
			a.index_error = 1'b1;
			if (rq == REQ_FIND)
				a.found_index = IDX_W'(lim);
		end else begin
			case (rq)
				REQ_READ: begin
					a.read_bit = bit_at(pos);
				end
				REQ_WRITE: begin
					bitmap[pos >> 3][7 - (pos & 7)] = val;
				end
				default: begin
					// find: walk down so the lowest set bit is the last one kept
					a.found_index = IDX_W'(lim);
					for (int i = lim - 1; i >= pos; i--)
						if (bit_at(i)) begin
							a.found       = 1'b1;
							a.found_index = IDX_W'(i);
						end
				end
			endcase
		end
		return a;
	endfunction

	task automatic check_field(string name, logic [IDX_W-1:0] want_v, logic [IDX_W-1:0] got_v);
		if (got_v !== want_v) begin
			$error("%s expected %0d actual %0d", name, want_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			for (int b = 0; b < NBYTES; b++)
				bitmap[b] = 8'h00;
			size_reg = SIZE_RST;
			answers_due.delete();
			errors   = 0;
			hits     = 0;
			oor      = 0;
			pending <= 0;
		end else begin
			if (cfg_we)
				size_reg = cfg_wdata;
			if (out_valid && out_ready) begin
				if (answers_due.size() == 0) begin
					$error("response with no request outstanding (found_index %0d)",
						found_index);
					errors++;
				end else begin
					want = answers_due.pop_front();
					check_field("read_bit", IDX_W'(want.read_bit), IDX_W'(read_bit));
					check_field("found", IDX_W'(want.found), IDX_W'(found));
					check_field("found_index", want.found_index, found_index);
					check_field("index_error", IDX_W'(want.index_error),
						IDX_W'(index_error));
					if (want.found)
						hits++;
					if (want.index_error)
						oor++;
				end
			end
			if (in_valid && in_ready)
				answers_due.push_back(apply_request(req_t'(req_type), bit_index, bit_value));
			pending <= answers_due.size();
		end
	end

endmodule

/* test/tb_bitmap_find_next_set.sv */
// ----------------------------------------------------------------------------
// tb_bitmap_find_next_set: randomized self-checking bench for the bit store
// Directed read/write/fill/find cases at full, partial-byte and zero size,
// then random phases over many sizes with idling on both ports, one long
// result stall and a mid-phase full drain; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_bitmap_find_next_set;
	timeunit 1ns;
	timeprecision 1ps;

	import bfns_pkg::*;

	localparam int MAX_BITS    = 1024;
	localparam int PHASE_ITEMS = 130;
	localparam int HOLD_CYCLES = 80;   // long result stall, fills the block up

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [IDX_W-1:0]  cfg_wdata;
	logic              in_valid;
	logic              in_ready;
	logic [1:0]        req_type;
	logic [BIDX_W-1:0] bit_index;
	logic              bit_value;
	logic              out_valid;
	logic              out_ready;
	logic              read_bit;
	logic              found;
	logic [IDX_W-1:0]  found_index;
	logic              index_error;

	int pending;
	int errors;
	int hits;
	int oor;

	bit quiet     = 1'b0;  // final stretch: no idling on either side
	int hold_asks = 0;     // long result stalls asked for by the sender side
	int hold_seen = 0;     // long result stalls taken by the result side
	int gap_pct   = 0;     // chance of a request-side idle burst per transaction
	int cur_size  = 1024;  // last size written, tracked for index picks
	int sent      = 0;
	int settings  = 0;

	// Size plan for the random phases; extremes first, full size last.
	// The entry marked -1 takes a random size.
	int size_plan [12] = '{2047, 13, 1, 0, 8, 9, 64, 65, -1, 1023, 1025, 1024};

	bitmap_find_next_set #(
		.MAX_BITS(MAX_BITS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.bit_index  (bit_index),
		.bit_value  (bit_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_bit   (read_bit),
		.found      (found),
		.found_index(found_index),
		.index_error(index_error)
	);

	bfns_answer_checker #(
		.MAX_BITS(MAX_BITS)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.bit_index  (bit_index),
		.bit_value  (bit_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_bit   (read_bit),
		.found      (found),
		.found_index(found_index),
		.index_error(index_error),
		.pending    (pending),
		.errors     (errors),
		.hits       (hits),
		.oor        (oor)
	);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Offers one request transaction, optionally after an idle burst, and
	// returns at the edge where it is accepted. Valid stays high across
	// back-to-back transactions, so each signal sees one update per edge.
	task automatic push_req(input req_t rq, input int idx, input logic val);
		if (!quiet && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		req_type  <= rq;
		bit_index <= BIDX_W'(idx);
		bit_value <= val;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	// Stops offering and waits until every outstanding answer has come back.
	// pending is a registered count, so the first edge is always waited.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Size register is only written with nothing in flight
	task automatic set_size(input int s);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= IDX_W'(s);
		@(posedge clk);
		cfg_we   <= 1'b0;
		cur_size  = s;
		settings++;
	endtask

	// Random request: mostly in-range, some near the end, some anywhere in the
	// 10-bit index space. Writes lean to setting bits and fills lean to zero,
	// which keeps the map sparse so searches skip over empty stretches.
	task automatic random_req();
		int   lim;
		int   pick;
		int   idx;
		req_t rq;
		logic val;
		lim  = (cur_size > MAX_BITS) ? MAX_BITS : cur_size;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			rq = REQ_WRITE;
		else if (pick < 62)
			rq = REQ_FIND;
		else if (pick < 96)
			rq = REQ_READ;
		else
			rq = REQ_FILL;
		case (rq)
			REQ_WRITE: val = ($urandom_range(0, 9) < 7);
			REQ_FILL:  val = ($urandom_range(0, 9) < 3);
			default:   val = 1'($urandom_range(0, 1));
		endcase
		pick = $urandom_range(0, 7);
		if (lim == 0 || pick == 0) begin
			idx = $urandom_range(0, 1023);
		end else if (pick == 1) begin
			idx = lim - 1 - int'($urandom_range(0, 7));
			if (idx < 0)
				idx = 0;
		end else begin
			idx = $urandom_range(0, lim - 1);
		end
		push_req(rq, idx, val);
	endtask

	// Result side: random stall bursts, calm stretches, and one long hold-off
	// on request while the sender keeps offering.
	initial begin
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				if (quiet)
					@(posedge clk);
				else
					repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("tb_bitmap_find_next_set: FAIL");
		$finish;
	end

	initial begin
		int s;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		in_valid  <= 1'b0;
		req_type  <= REQ_READ;
		bit_index <= '0;
		bit_value <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed, size at reset value (1024) ---
		// in_ready stays low during the clearing pass; push_req waits it out
		push_req(REQ_READ, 0, 1'b1);      // bit value ignored on read
		push_req(REQ_FIND, 0, 1'b0);      // empty map: end marker
		push_req(REQ_WRITE, 0, 1'b1);
		push_req(REQ_WRITE, 7, 1'b1);     // last bit of byte 0
		push_req(REQ_WRITE, 8, 1'b1);
		push_req(REQ_WRITE, 1023, 1'b1);  // top index
		push_req(REQ_READ, 0, 1'b0);
		push_req(REQ_READ, 1023, 1'b0);
		push_req(REQ_FIND, 1, 1'b1);      // bit value ignored on search
		push_req(REQ_FIND, 9, 1'b0);      // long skip to the top bit
		push_req(REQ_FIND, 1023, 1'b0);
		push_req(REQ_WRITE, 0, 1'b0);     // clear a bit
		push_req(REQ_FIND, 0, 1'b0);
		push_req(REQ_FILL, 1023, 1'b1);   // index ignored on fill
		push_req(REQ_READ, 555, 1'b0);
		push_req(REQ_FILL, 0, 1'b0);
		push_req(REQ_FIND, 0, 1'b0);

		// partial last byte: out-of-range write/read/search, fill spare bits
		set_size(13);
		push_req(REQ_WRITE, 12, 1'b1);
		push_req(REQ_FIND, 0, 1'b0);
		push_req(REQ_WRITE, 13, 1'b1);
		push_req(REQ_READ, 13, 1'b0);
		push_req(REQ_FIND, 13, 1'b0);
		push_req(REQ_FILL, 0, 1'b1);
		push_req(REQ_FIND, 12, 1'b0);

		// zero size: every indexed request is out of range, fill touches nothing
		set_size(0);
		push_req(REQ_READ, 0, 1'b0);
		push_req(REQ_WRITE, 0, 1'b1);
		push_req(REQ_FIND, 0, 1'b0);
		push_req(REQ_FILL, 0, 1'b1);

		// --- random phases, one size each ---
		foreach (size_plan[p]) begin
			s = (size_plan[p] < 0) ? int'($urandom_range(2, 1022)) : size_plan[p];
			case ($urandom_range(0, 2))
				0:       gap_pct = 0;
				1:       gap_pct = 15;
				default: gap_pct = 40;
			endcase
			if (p == $size(size_plan) - 1) begin
				quiet   = 1'b1;
				gap_pct = 0;
			end
			set_size(s);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// long result stall while requests keep coming
				if (p == 0 && k == 10)
					hold_asks++;
				// sender pause until the pipe is empty
				if (p == 1 && k == 50)
					drain();
				random_req();
			end
		end

		drain();
		repeat (40) @(posedge clk);

		$display("Ran %0d requests over %0d size settings (0 to 2047).", sent, settings);
		$display("%0d searches hit a set bit, %0d requests were out of range.", hits, oor);
		if (errors == 0)
			$display("tb_bitmap_find_next_set: PASS");
		else
			$display("tb_bitmap_find_next_set: FAIL");
		$finish;
	end

endmodule
